>>> design/legc_pkg.sv
// Shared types, constants and helper functions of the luma energy and gradient core.
package legc_pkg;

    localparam int MAX_WIDTH_DEFAULT = 2048;

    localparam int CHANNEL_W      = 8;
    localparam int SUM_W          = 10;
    localparam int ENERGY_W       = 16;
    localparam int GRADIENT_W     = 12;
    localparam int COLUMN_W       = 11;
    localparam int ROW_W          = 16;
    localparam int IMAGE_WIDTH_W  = 12;
    localparam int IMAGE_HEIGHT_W = 16;
    localparam int CFG_INDEX_W    = 2;
    localparam int CFG_DATA_W     = 16;
    localparam int LUMA_ACC_W     = 24;

    localparam logic [IMAGE_WIDTH_W-1:0]  IMAGE_WIDTH_RESET  = 12'd640;
    localparam logic [IMAGE_HEIGHT_W-1:0] IMAGE_HEIGHT_RESET = 16'd480;

    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

    // Luma weights scaled to 2^16, plus rounding before the >> 8
    localparam logic [LUMA_ACC_W-1:0] LUMA_R_WEIGHT = 24'd13933;
    localparam logic [LUMA_ACC_W-1:0] LUMA_G_WEIGHT = 24'd46871;
    localparam logic [LUMA_ACC_W-1:0] LUMA_B_WEIGHT = 24'd4732;
    localparam logic [LUMA_ACC_W-1:0] LUMA_ROUND    = 24'd128;

    localparam int RESULTS_PER_PIXEL = 4;
    localparam int QUEUE_DEPTH       = 8;
    localparam int QUEUE_PTR_W       = 3;
    localparam int QUEUE_CNT_W       = 4;
    localparam int PUSH_CNT_W        = 3;

    // One line-store word: intensity sum in the low bits, energy above it
    typedef struct packed {
        logic [ENERGY_W-1:0] energy;
        logic [SUM_W-1:0]    sum;
    } pixel_word_t;

    localparam int LINE_WORD_W = $bits(pixel_word_t);

    typedef struct packed {
        logic [ENERGY_W-1:0]          energy;
        logic signed [GRADIENT_W-1:0] gradient_x;
        logic signed [GRADIENT_W-1:0] gradient_y;
        logic [COLUMN_W-1:0]          column;
        logic [ROW_W-1:0]             row;
        logic                         last_of_run;
        logic                         end_of_frame;
    } result_t;

    // Position of a pixel in the frame, decoded when it is accepted
    typedef struct packed {
        logic row_end;
        logic last_row;
        logic col_is0;
        logic col_is1;
        logic row_is0;
        logic row_is1;
        logic w_is1;
        logic h_is1;
        logic older_bank;
    } pos_flags_t;

    function automatic logic [ENERGY_W-1:0] energy_of(
        input logic [CHANNEL_W-1:0] r,
        input logic [CHANNEL_W-1:0] g,
        input logic [CHANNEL_W-1:0] b
    );
        logic [LUMA_ACC_W-1:0] acc;
        acc = LUMA_R_WEIGHT * LUMA_ACC_W'(r) + LUMA_G_WEIGHT * LUMA_ACC_W'(g)
            + LUMA_B_WEIGHT * LUMA_ACC_W'(b) + LUMA_ROUND;
        return acc[LUMA_ACC_W-1:8];
    endfunction

    // ahead - behind, doubled for one-sided differences at an edge
    function automatic logic signed [GRADIENT_W-1:0] slope_of(
        input logic [SUM_W-1:0] ahead,
        input logic [SUM_W-1:0] behind,
        input logic             twice
    );
        logic signed [GRADIENT_W-1:0] d;
        d = $signed({2'b00, ahead}) - $signed({2'b00, behind});
        return twice ? (d <<< 1) : d;
    endfunction

endpackage

>>> design/luma_energy_and_gradient_core.sv
// Luma energy and central-difference intensity gradient core (top level).
//
// Takes one RGB pixel per clock in raster order and returns, per pixel, a 16-bit
// luma energy and x/y gradients of R+G+B (units of 1/1530, one-sided and doubled
// at the frame edges, zero along a dimension of one). The result for pixel
// (x-1,y-1) comes out after pixel (x,y) is taken; row ends add one more result and
// the last row emits its own results too, so one pixel can give up to four. A
// pixel waits in the input register, where the two line stores (2 x MAX_WIDTH
// words of 26 bits, read and written once per pixel) have already been read,
// until the 8-entry queue has room for its results, which then enter it together.
// Sustained rate is one pixel per clock as long as the queue has room for that
// pixel's results; it drains one result per clock unless the output stalls, so
// in the last row (two results per pixel) input slows to match the output. The
// line stores need no clearing after reset. Configuration writes to a known
// register (ready is always high) restart the frame position at (0,0).
module luma_energy_and_gradient_core #(
    parameter int MAX_WIDTH = legc_pkg::MAX_WIDTH_DEFAULT
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [legc_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [legc_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  logic                                   pixel_valid,
    output logic                                   pixel_stall,
    input  logic [legc_pkg::CHANNEL_W-1:0]         red,
    input  logic [legc_pkg::CHANNEL_W-1:0]         green,
    input  logic [legc_pkg::CHANNEL_W-1:0]         blue,
    output logic                                   result_valid,
    input  logic                                   result_stall,
    output logic [legc_pkg::ENERGY_W-1:0]          energy,
    output logic signed [legc_pkg::GRADIENT_W-1:0] gradient_x,
    output logic signed [legc_pkg::GRADIENT_W-1:0] gradient_y,
    output logic [legc_pkg::COLUMN_W-1:0]          column,
    output logic [legc_pkg::ROW_W-1:0]             row,
    output logic                                   last_of_run,
    output logic                                   end_of_frame
);
    import legc_pkg::*;

    localparam int AW     = $clog2(MAX_WIDTH);
    localparam int WLIM_W = ($clog2(MAX_WIDTH + 1) > IMAGE_WIDTH_W) ?
                            $clog2(MAX_WIDTH + 1) : IMAGE_WIDTH_W;

    // configuration and frame position
    logic [IMAGE_WIDTH_W-1:0]  image_width_reg, image_width_next;
    logic [IMAGE_HEIGHT_W-1:0] image_height_reg, image_height_next;
    logic [AW-1:0]             col_reg, col_next;
    logic [ROW_W-1:0]          row_reg, row_next;
    logic                      bank_reg, bank_next;
    logic                      cfg_known;
    logic [WLIM_W-1:0]         width_wide;
    logic [AW-1:0]             w_last;
    logic [ROW_W-1:0]          h_last;
    logic                      at_row_end;
    logic                      at_last_row;
    logic                      accept;

    // input register
    logic                 s1_valid_reg, s1_valid_next;
    logic [CHANNEL_W-1:0] s1_red_reg, s1_green_reg, s1_blue_reg;
    logic [AW-1:0]        s1_col_reg;
    logic [ROW_W-1:0]     s1_row_reg;
    pos_flags_t           s1_flags_reg;
    pos_flags_t           flags_in;
    logic                 s1_adv;

    // sliding window over the line stores and the current row
    pixel_word_t n1_reg, n2_reg, o1_reg, p0_reg, p1_reg;
    pixel_word_t rd_newer, rd_older, cur;
    logic [LINE_WORD_W-1:0] rd_a, rd_b;

    // results
    logic [RESULTS_PER_PIXEL-1:0]             res_v;
    result_t [RESULTS_PER_PIXEL-1:0]          res;
    logic [RESULTS_PER_PIXEL-1:0]             push_mask;
    logic [QUEUE_CNT_W-1:0]                   space;
    logic [PUSH_CNT_W-1:0]                    need;
    logic [AW-1:0]                            col_m1;
    logic [ROW_W-1:0]                         row_m1;
    result_t                                  head;

    assign cfg_ready = 1'b1;
    assign cfg_known = (cfg_index == REG_IMAGE_WIDTH) || (cfg_index == REG_IMAGE_HEIGHT);

    always_comb
    begin
        image_width_next  = image_width_reg;
        image_height_next = image_height_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_IMAGE_WIDTH:  image_width_next  = cfg_data[IMAGE_WIDTH_W-1:0];
                REG_IMAGE_HEIGHT: image_height_next = cfg_data[IMAGE_HEIGHT_W-1:0];
                default:          ;
            endcase
        end
    end

    // width is clamped to 1..MAX_WIDTH, height zero counts as one
    always_comb
    begin
        width_wide = WLIM_W'(image_width_reg);
        if (width_wide == '0)
            w_last = '0;
        else if (width_wide > WLIM_W'(MAX_WIDTH))
            w_last = AW'(MAX_WIDTH - 1);
        else
            w_last = AW'(width_wide - 1'b1);
        h_last = (image_height_reg == '0) ? '0 : image_height_reg - 1'b1;
    end

    assign at_row_end  = (col_reg == w_last);
    assign at_last_row = (row_reg == h_last);
    assign accept      = pixel_valid && !pixel_stall;

    always_comb
    begin
        col_next  = col_reg;
        row_next  = row_reg;
        bank_next = bank_reg;
        if (cfg_valid && cfg_known)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (accept)
        begin
            if (at_row_end)
            begin
                col_next  = '0;
                row_next  = at_last_row ? '0 : row_reg + 1'b1;
                bank_next = ~bank_reg;
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    always_comb
    begin
        flags_in.row_end    = at_row_end;
        flags_in.last_row   = at_last_row;
        flags_in.col_is0    = (col_reg == '0);
        flags_in.col_is1    = (col_reg == AW'(1));
        flags_in.row_is0    = (row_reg == '0);
        flags_in.row_is1    = (row_reg == ROW_W'(1));
        flags_in.w_is1      = (w_last == '0);
        flags_in.h_is1      = (h_last == '0);
        flags_in.older_bank = bank_reg;
    end

    assign s1_adv      = s1_valid_reg && (QUEUE_CNT_W'(need) <= space);
    assign pixel_stall = s1_valid_reg && !s1_adv;

    always_comb
    begin
        if (accept)
            s1_valid_next = 1'b1;
        else if (s1_adv)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= IMAGE_WIDTH_RESET;
            image_height_reg <= IMAGE_HEIGHT_RESET;
            col_reg          <= '0;
            row_reg          <= '0;
            bank_reg         <= 1'b0;
            s1_valid_reg     <= 1'b0;
        end
        else
        begin
            image_width_reg  <= image_width_next;
            image_height_reg <= image_height_next;
            col_reg          <= col_next;
            row_reg          <= row_next;
            bank_reg         <= bank_next;
            s1_valid_reg     <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_red_reg   <= red;
            s1_green_reg <= green;
            s1_blue_reg  <= blue;
            s1_col_reg   <= col_reg;
            s1_row_reg   <= row_reg;
            s1_flags_reg <= flags_in;
        end
        if (s1_adv)
        begin
            n1_reg <= rd_newer;
            n2_reg <= n1_reg;
            o1_reg <= rd_older;
            p1_reg <= p0_reg;
            p0_reg <= cur;
        end
    end

    // Both stores are read at the incoming column; the older one is then
    // overwritten there with the current pixel, so a row end just swaps roles.
    legc_line_ram #(
        .DEPTH (MAX_WIDTH),
        .WIDTH (LINE_WORD_W)
    ) u_bank_a (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (col_reg),
        .rd_data (rd_a),
        .wr_en   (s1_adv && !s1_flags_reg.older_bank),
        .wr_addr (s1_col_reg),
        .wr_data (cur)
    );

    legc_line_ram #(
        .DEPTH (MAX_WIDTH),
        .WIDTH (LINE_WORD_W)
    ) u_bank_b (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (col_reg),
        .rd_data (rd_b),
        .wr_en   (s1_adv && s1_flags_reg.older_bank),
        .wr_addr (s1_col_reg),
        .wr_data (cur)
    );

    assign rd_older = s1_flags_reg.older_bank ? rd_b : rd_a;
    assign rd_newer = s1_flags_reg.older_bank ? rd_a : rd_b;

    always_comb
    begin
        cur.energy = energy_of(s1_red_reg, s1_green_reg, s1_blue_reg);
        cur.sum    = SUM_W'(s1_red_reg) + SUM_W'(s1_green_reg) + SUM_W'(s1_blue_reg);
    end

    assign col_m1 = s1_col_reg - 1'b1;
    assign row_m1 = s1_row_reg - 1'b1;

    // Order: (x-1,y-1), (W-1,y-1) at a row end, then (x-1,y) and (W-1,y) in the last row
    always_comb
    begin
        res_v[0] = s1_valid_reg && !s1_flags_reg.row_is0 && !s1_flags_reg.col_is0;
        res_v[1] = s1_valid_reg && !s1_flags_reg.row_is0 && s1_flags_reg.row_end;
        res_v[2] = s1_valid_reg && s1_flags_reg.last_row && !s1_flags_reg.col_is0;
        res_v[3] = s1_valid_reg && s1_flags_reg.last_row && s1_flags_reg.row_end;

        res[0].energy     = n1_reg.energy;
        res[0].gradient_x = s1_flags_reg.col_is1 ? slope_of(rd_newer.sum, n1_reg.sum, 1'b1)
                                                 : slope_of(rd_newer.sum, n2_reg.sum, 1'b0);
        res[0].gradient_y = s1_flags_reg.row_is1 ? slope_of(p0_reg.sum, n1_reg.sum, 1'b1)
                                                 : slope_of(p0_reg.sum, o1_reg.sum, 1'b0);
        res[0].column     = COLUMN_W'(col_m1);
        res[0].row        = row_m1;
        res[0].end_of_frame = 1'b0;

        res[1].energy     = rd_newer.energy;
        res[1].gradient_x = s1_flags_reg.w_is1 ? '0 : slope_of(rd_newer.sum, n1_reg.sum, 1'b1);
        res[1].gradient_y = s1_flags_reg.row_is1 ? slope_of(cur.sum, rd_newer.sum, 1'b1)
                                                 : slope_of(cur.sum, rd_older.sum, 1'b0);
        res[1].column     = COLUMN_W'(s1_col_reg);
        res[1].row        = row_m1;
        res[1].end_of_frame = 1'b0;

        res[2].energy     = p0_reg.energy;
        res[2].gradient_x = s1_flags_reg.col_is1 ? slope_of(cur.sum, p0_reg.sum, 1'b1)
                                                 : slope_of(cur.sum, p1_reg.sum, 1'b0);
        res[2].gradient_y = s1_flags_reg.h_is1 ? '0 : slope_of(p0_reg.sum, n1_reg.sum, 1'b1);
        res[2].column     = COLUMN_W'(col_m1);
        res[2].row        = s1_row_reg;
        res[2].end_of_frame = 1'b0;

        res[3].energy     = cur.energy;
        res[3].gradient_x = s1_flags_reg.w_is1 ? '0 : slope_of(cur.sum, p0_reg.sum, 1'b1);
        res[3].gradient_y = s1_flags_reg.h_is1 ? '0 : slope_of(cur.sum, rd_newer.sum, 1'b1);
        res[3].column     = COLUMN_W'(s1_col_reg);
        res[3].row        = s1_row_reg;
        res[3].end_of_frame = 1'b1;

        res[0].last_of_run = !(res_v[1] || res_v[2] || res_v[3]);
        res[1].last_of_run = !(res_v[2] || res_v[3]);
        res[2].last_of_run = !res_v[3];
        res[3].last_of_run = 1'b1;
    end

    assign need      = PUSH_CNT_W'($countones(res_v));
    assign push_mask = s1_adv ? res_v : '0;

    legc_result_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_mask  (push_mask),
        .push_data  (res),
        .space      (space),
        .head_valid (result_valid),
        .head_stall (result_stall),
        .head       (head)
    );

    assign energy       = head.energy;
    assign gradient_x   = head.gradient_x;
    assign gradient_y   = head.gradient_y;
    assign column       = head.column;
    assign row          = head.row;
    assign last_of_run  = head.last_of_run;
    assign end_of_frame = head.end_of_frame;

endmodule

>>> design/legc_line_ram.sv
// Single-port-write, single-port-read line store with registered, write-first read data.
module legc_line_ram #(
    parameter int DEPTH = 2048,
    parameter int WIDTH = 26
) (
    input  logic                     clk,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // a write landing on the same edge as the read is passed straight through
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= (wr_en && (wr_addr == rd_addr)) ? wr_data : mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> design/legc_result_queue.sv
// Result queue: takes up to four results per cycle, hands out one per cycle unless stalled.
module legc_result_queue (
    input  logic                                              clk,
    input  logic                                              rst_n,
    input  logic [legc_pkg::RESULTS_PER_PIXEL-1:0]            push_mask,
    input  legc_pkg::result_t [legc_pkg::RESULTS_PER_PIXEL-1:0] push_data,
    output logic [legc_pkg::QUEUE_CNT_W-1:0]                  space,
    output logic                                              head_valid,
    input  logic                                              head_stall,
    output legc_pkg::result_t                                 head
);
    import legc_pkg::*;

    result_t                mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg, count_next;
    logic [QUEUE_PTR_W-1:0] wr_idx [RESULTS_PER_PIXEL];
    logic [PUSH_CNT_W-1:0]  push_n;
    logic                   pop;

    // results are packed into consecutive slots in their original order
    always_comb
    begin
        push_n = '0;
        for (int k = 0; k < RESULTS_PER_PIXEL; k++)
        begin
            wr_idx[k] = wr_ptr_reg + QUEUE_PTR_W'(push_n);
            push_n    = push_n + PUSH_CNT_W'(push_mask[k]);
        end
    end

    assign head_valid = (count_reg != '0);
    assign pop        = head_valid && !head_stall;
    assign head       = mem[rd_ptr_reg];
    assign space      = QUEUE_CNT_W'(QUEUE_DEPTH) - count_reg;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + QUEUE_PTR_W'(push_n);
        rd_ptr_next = rd_ptr_reg + QUEUE_PTR_W'(pop);
        count_next  = count_reg + QUEUE_CNT_W'(push_n) - QUEUE_CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < RESULTS_PER_PIXEL; k++)
        begin
            if (push_mask[k])
            begin
                mem[wr_idx[k]] <= push_data[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> design/legc_checker.sv
// Port-level checks of the luma energy and gradient core, bound to the top level.
module legc_checker (
    input logic                                   clk,
    input logic                                   rst_n,
    input logic                                   cfg_valid,
    input logic                                   cfg_ready,
    input logic [legc_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input logic [legc_pkg::CFG_DATA_W-1:0]        cfg_data,
    input logic                                   pixel_valid,
    input logic                                   pixel_stall,
    input logic [legc_pkg::CHANNEL_W-1:0]         red,
    input logic [legc_pkg::CHANNEL_W-1:0]         green,
    input logic [legc_pkg::CHANNEL_W-1:0]         blue,
    input logic                                   result_valid,
    input logic                                   result_stall,
    input logic [legc_pkg::ENERGY_W-1:0]          energy,
    input logic signed [legc_pkg::GRADIENT_W-1:0] gradient_x,
    input logic signed [legc_pkg::GRADIENT_W-1:0] gradient_y,
    input logic [legc_pkg::COLUMN_W-1:0]          column,
    input logic [legc_pkg::ROW_W-1:0]             row,
    input logic                                   last_of_run,
    input logic                                   end_of_frame
);

    // a stalled result request keeps its contents
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(energy)
            && $stable(gradient_x) && $stable(gradient_y) && $stable(column)
            && $stable(row) && $stable(last_of_run) && $stable(end_of_frame))
        else $error("result request changed while stalled");

    // the frame's final pixel is always the last result of its run
    a_eof_closes_run: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && end_of_frame |-> last_of_run)
        else $error("end_of_frame without last_of_run");

    a_value_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (energy <= 16'd65280)
            && (gradient_x >= -12'sd1530) && (gradient_x <= 12'sd1530)
            && (gradient_y >= -12'sd1530) && (gradient_y <= 12'sd1530))
        else $error("result value out of range");

endmodule

bind luma_energy_and_gradient_core legc_checker u_legc_checker (.*);
